>>> design/raster_to_column_band_printer_defines.svh
// Assertion macros for the checker file of this block.
`ifndef RASTER_TO_COLUMN_BAND_PRINTER_DEFINES_SVH
`define RASTER_TO_COLUMN_BAND_PRINTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTCBP_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTCBP_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rtcbp_pkg.sv
package rtcbp_pkg;

  // Result kinds carried on the output tuser.
  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_BAND_END = 2'd1;
  localparam logic [1:0] KIND_PAGE_END = 2'd2;
  localparam logic [1:0] KIND_REJECT   = 2'd3;

  // Input beat kinds carried on the input tuser.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_LINE_BYTES = 2'd0;
  localparam logic [1:0] REG_PAGE_ROWS  = 2'd1;
  localparam logic [1:0] REG_HIGH_RES   = 2'd2;

  // Printer command bytes.
  localparam logic [7:0] CHR_ESC  = 8'd27;
  localparam logic [7:0] CHR_3    = 8'd51;
  localparam logic [7:0] CHR_24   = 8'd24;
  localparam logic [7:0] CHR_L    = 8'd76;
  localparam logic [7:0] CHR_K    = 8'd75;
  localparam logic [7:0] CHR_LF   = 8'd10;
  localparam logic [7:0] CHR_NINE = 8'd57;

  localparam int unsigned PRE_LEN = 10;
  localparam int unsigned HDR_LEN = 7;
  localparam int unsigned TRL_LAST = 4;

  // Page preamble: reset, 24/180 inch line spacing, paper-out off, charset 1 (France).
  localparam logic [7:0] PRE_SEQ [PRE_LEN] = '{
    8'd27, 8'd64, 8'd27, 8'd51, 8'd24, 8'd27, 8'd56, 8'd27, 8'd82, 8'd1
  };

  // Page trailer: three bells and paper-out detection back on.
  localparam logic [7:0] TRL_SEQ [TRL_LAST + 1] = '{
    8'd7, 8'd7, 8'd7, 8'd27, 8'd57
  };

endpackage

>>> design/raster_to_column_band_printer.sv
// Channel   Dir  Beat contents
// s_axis    in   tdata: pixel_byte; tuser: cmd (pixel byte or drain tick)
// m_axis    out  tdata: out_byte; tuser: kind
// cfg       in   cfg_idx_i selects line_bytes, page_rows or high_res
//
// One beat per cycle on either side while no stall holds the flow.
// A pixel beat does a read-modify-write of one band memory entry via rdata_q and stage one;
// a write to the same entry in the cycle before is forwarded to the merge.
// A tick beat outside idle gives one printer byte; column bytes come from one memory read.
// The band memory needs no clearing pass: per-entry valid bits clear at reset and at LF.
// A stalled output register holds its beat; input stalls only when it and the stage before it are full.
module raster_to_column_band_printer #(
  parameter int unsigned MaxLineBytes = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_byte
  input  logic        s_axis_tuser,   // [0] cmd
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]  m_axis_tuser    // [1:0] kind
);
  import rtcbp_pkg::*;

  localparam int unsigned AW  = (MaxLineBytes > 1) ? $clog2(MaxLineBytes) : 1;
  localparam int unsigned LBW = (AW + 1 > 8) ? AW + 1 : 8;
  localparam int unsigned LDW = $clog2(8 * MaxLineBytes + 1);

  // Emit sequencer codes.
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_PRE  = 3'd1;
  localparam logic [2:0] PH_HDR  = 3'd2;
  localparam logic [2:0] PH_COLS = 3'd3;
  localparam logic [2:0] PH_LF   = 3'd4;
  localparam logic [2:0] PH_TRL  = 3'd5;

  // Index of the lowest set bit.
  function automatic logic [2:0] low_bit(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

  // Configuration registers.
  logic [7:0]  line_bytes_q;
  logic [15:0] page_rows_q;
  logic        high_res_q;

  // Band memory and per-entry valid bits.
  logic [63:0]           mem_q [MaxLineBytes];
  logic [63:0]           rdata_q;
  logic [MaxLineBytes-1:0] valid_q, valid_d;

  // Sequencer state.
  logic [AW-1:0]  byte_col_q, byte_col_d;
  logic [2:0]     row_band_q, row_band_d;
  logic [15:0]    row_page_q, row_page_d;
  logic [LDW-1:0] last_dark_q, last_dark_d;
  logic [2:0]     phase_q, phase_d;
  logic [LDW-1:0] count_q, count_d;
  logic           page_begun_q, page_begun_d;

  // Stage one: memory data arrives here.
  logic          s1_pix_q, s1_pix_d;
  logic          s1_res_q, s1_res_d;
  logic          s1_mem_q, s1_mem_d;
  logic [AW-1:0] s1_addr_q, s1_addr_d;
  logic [2:0]    s1_row_q, s1_row_d;
  logic [7:0]    s1_px_q, s1_px_d;
  logic [2:0]    s1_sel_q, s1_sel_d;
  logic [7:0]    s1_byte_q, s1_byte_d;
  logic [1:0]    s1_kind_q, s1_kind_d;

  // Forwarding of the previous cycle's write.
  logic          fwd_vld_q;
  logic [AW-1:0] fwd_addr_q;
  logic [63:0]   fwd_data_q;

  // Output register.
  logic       out_vld_q;
  logic [7:0] out_byte_q;
  logic [1:0] out_kind_q;

  logic           out_free, accept, clear_band;
  logic [AW-1:0]  rd_addr;
  logic [LBW-1:0] eff_lb, col_inc;
  logic [15:0]    eff_pr, row_inc;
  logic [LDW-1:0] cand, count_inc;
  logic [15:0]    dark16;
  logic [63:0]    merge_base, merge_bits, wr_data;
  logic [7:0]     mem_byte;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !s1_res_q || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_kind_q;

  // Effective line length and page height.
  always_comb begin
    if (line_bytes_q == 8'd0) begin
      eff_lb = LBW'(1);
    end else if (LBW'(line_bytes_q) > LBW'(MaxLineBytes)) begin
      eff_lb = LBW'(MaxLineBytes);
    end else begin
      eff_lb = LBW'(line_bytes_q);
    end
    eff_pr = (page_rows_q == 16'd0) ? 16'd1 : page_rows_q;
  end

  assign col_inc   = LBW'(byte_col_q) + LBW'(1);
  assign row_inc   = row_page_q + 16'd1;
  assign count_inc = count_q + LDW'(1);
  assign cand      = LDW'({byte_col_q, 3'b000}) + LDW'(8) - LDW'(low_bit(s_axis_tdata));
  assign dark16    = 16'(last_dark_q);

  // Next state of the sequencer and of stage one for an accepted beat.
  always_comb begin
    byte_col_d   = byte_col_q;
    row_band_d   = row_band_q;
    row_page_d   = row_page_q;
    last_dark_d  = last_dark_q;
    phase_d      = phase_q;
    count_d      = count_q;
    page_begun_d = page_begun_q;
    clear_band   = 1'b0;
    rd_addr      = byte_col_q;
    s1_pix_d     = 1'b0;
    s1_res_d     = 1'b0;
    s1_mem_d     = 1'b0;
    s1_addr_d    = byte_col_q;
    s1_row_d     = row_band_q;
    s1_px_d      = s_axis_tdata;
    s1_sel_d     = count_q[2:0];
    s1_byte_d    = 8'd0;
    s1_kind_d    = KIND_BYTE;

    if (accept && s_axis_tuser == CMD_PIXEL) begin
      if (phase_q != PH_IDLE) begin
        s1_res_d  = 1'b1;
        s1_kind_d = KIND_REJECT;
      end else begin
        s1_pix_d = 1'b1;
        if (s_axis_tdata != 8'd0 && cand > last_dark_q) begin
          last_dark_d = cand;
        end
        byte_col_d = col_inc[AW-1:0];
        if (col_inc >= eff_lb) begin
          byte_col_d = '0;
          row_page_d = row_inc;
          row_band_d = row_band_q + 3'd1;
          if (row_band_q == 3'd7 || row_inc >= eff_pr) begin
            row_band_d = 3'd0;
            count_d    = '0;
            if (!page_begun_q) begin
              phase_d = PH_PRE;
            end else if (last_dark_d != '0) begin
              phase_d = PH_HDR;
            end else begin
              phase_d = PH_LF;
            end
          end
        end
      end
    end else if (accept) begin
      s1_res_d = (phase_q != PH_IDLE);
      unique case (phase_q)
        PH_PRE: begin
          s1_byte_d = PRE_SEQ[count_q[3:0]];
          count_d   = count_inc;
          if (count_inc >= LDW'(PRE_LEN)) begin
            page_begun_d = 1'b1;
            count_d      = '0;
            phase_d      = (last_dark_q != '0) ? PH_HDR : PH_LF;
          end
        end
        PH_HDR: begin
          unique case (count_q[2:0])
            3'd0:    s1_byte_d = CHR_ESC;
            3'd1:    s1_byte_d = CHR_3;
            3'd2:    s1_byte_d = CHR_24;
            3'd3:    s1_byte_d = CHR_ESC;
            3'd4:    s1_byte_d = high_res_q ? CHR_L : CHR_K;
            3'd5:    s1_byte_d = dark16[7:0];
            default: s1_byte_d = dark16[15:8];
          endcase
          count_d = count_inc;
          if (count_inc >= LDW'(HDR_LEN)) begin
            count_d = '0;
            phase_d = PH_COLS;
          end
        end
        PH_COLS: begin
          rd_addr   = count_q[AW+2:3];
          s1_addr_d = count_q[AW+2:3];
          s1_mem_d  = 1'b1;
          count_d   = count_inc;
          if (count_inc >= last_dark_q) begin
            count_d = '0;
            phase_d = PH_LF;
          end
        end
        PH_LF: begin
          s1_byte_d   = CHR_LF;
          s1_kind_d   = KIND_BAND_END;
          clear_band  = 1'b1;
          last_dark_d = '0;
          count_d     = '0;
          phase_d     = (row_page_q >= eff_pr) ? PH_TRL : PH_IDLE;
        end
        PH_TRL: begin
          if (count_q >= LDW'(TRL_LAST)) begin
            s1_byte_d    = TRL_SEQ[TRL_LAST];
            s1_kind_d    = KIND_PAGE_END;
            row_page_d   = 16'd0;
            page_begun_d = 1'b0;
            count_d      = '0;
            phase_d      = PH_IDLE;
          end else begin
            s1_byte_d = TRL_SEQ[count_q[2:0]];
            count_d   = count_inc;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // Merge of a pixel beat into its memory entry, bit 7 of each column byte on top.
  always_comb begin
    if (fwd_vld_q && fwd_addr_q == s1_addr_q) begin
      merge_base = fwd_data_q;
    end else if (valid_q[s1_addr_q]) begin
      merge_base = rdata_q;
    end else begin
      merge_base = '0;
    end
    merge_bits = '0;
    for (int k = 0; k < 8; k++) begin
      merge_bits[k*8 + 7 - 32'(s1_row_q)] = s1_px_q[7 - k];
    end
    wr_data  = merge_base | merge_bits;
    mem_byte = valid_q[s1_addr_q] ? rdata_q[{s1_sel_q, 3'b000} +: 8] : 8'd0;
  end

  // Valid bits: set by a pixel write, all cleared when the band's LF tick is accepted.
  always_comb begin
    valid_d = valid_q;
    if (s1_pix_q) begin
      valid_d[s1_addr_q] = 1'b1;
    end
    if (clear_band) begin
      valid_d = '0;
    end
  end

  // Band memory: one registered read per accepted beat, one write per pixel.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= mem_q[rd_addr];
    end
    if (s1_pix_q) begin
      mem_q[s1_addr_q] <= wr_data;
    end
  end

  // Stage one payload.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready) begin
      s1_mem_q  <= s1_mem_d;
      s1_addr_q <= s1_addr_d;
      s1_row_q  <= s1_row_d;
      s1_px_q   <= s1_px_d;
      s1_sel_q  <= s1_sel_d;
      s1_byte_q <= s1_byte_d;
      s1_kind_q <= s1_kind_d;
    end
    fwd_addr_q <= s1_addr_q;
    fwd_data_q <= wr_data;
    if (out_free && s1_res_q) begin
      out_byte_q <= s1_mem_q ? mem_byte : s1_byte_q;
      out_kind_q <= s1_kind_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_bytes_q <= 8'd120;
      page_rows_q  <= 16'd792;
      high_res_q   <= 1'b1;
      valid_q      <= '0;
      byte_col_q   <= '0;
      row_band_q   <= 3'd0;
      row_page_q   <= 16'd0;
      last_dark_q  <= '0;
      phase_q      <= PH_IDLE;
      count_q      <= '0;
      page_begun_q <= 1'b0;
      s1_pix_q     <= 1'b0;
      s1_res_q     <= 1'b0;
      fwd_vld_q    <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_LINE_BYTES: line_bytes_q <= cfg_data_i[7:0];
          REG_PAGE_ROWS:  page_rows_q  <= cfg_data_i;
          REG_HIGH_RES:   high_res_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      valid_q      <= valid_d;
      byte_col_q   <= byte_col_d;
      row_band_q   <= row_band_d;
      row_page_q   <= row_page_d;
      last_dark_q  <= last_dark_d;
      phase_q      <= phase_d;
      count_q      <= count_d;
      page_begun_q <= page_begun_d;
      s1_pix_q     <= s1_pix_d;
      fwd_vld_q    <= s1_pix_q;
      if (s_axis_tready) begin
        s1_res_q <= s1_res_d;
      end
      if (out_free) begin
        out_vld_q <= s1_res_q;
      end
    end
  end

endmodule

>>> design/rtcbp_checker.sv
`include "raster_to_column_band_printer_defines.svh"

// Port-level checks on the printer byte stream.
module rtcbp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser
);
  import rtcbp_pkg::*;

  // A stalled result beat keeps its byte and kind.
  `RTCBP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output beat changed while stalled")

  // A rejected pixel beat reports a zero byte.
  `RTCBP_ASSERT_NOW(a_reject_zero, m_axis_tvalid && m_axis_tuser == KIND_REJECT, m_axis_tdata == 8'd0, "reject beat carries data")

  // Each band closes with a line feed.
  `RTCBP_ASSERT_NOW(a_band_lf, m_axis_tvalid && m_axis_tuser == KIND_BAND_END, m_axis_tdata == CHR_LF, "band end is not a line feed")

  // Each page closes with the final trailer byte.
  `RTCBP_ASSERT_NOW(a_page_end, m_axis_tvalid && m_axis_tuser == KIND_PAGE_END, m_axis_tdata == CHR_NINE, "page end byte is wrong")

endmodule

bind raster_to_column_band_printer rtcbp_checker u_rtcbp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> sim/tb_raster_to_column_band_printer.sv
`timescale 1ns / 1ps

module tb_raster_to_column_band_printer;
  import rtcbp_pkg::*;

  localparam int unsigned MAX_LINE = 128;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES = 200;

  // Printer command bytes, kept apart from the package so the checks stand on their own.
  localparam logic [7:0] ESC_BYTE = 8'd27;
  localparam logic [7:0] SPACING_CHAR = 8'h33;
  localparam logic [7:0] SPACING_24 = 8'd24;
  localparam logic [7:0] DENSE_CHAR = 8'h4C;
  localparam logic [7:0] SPARSE_CHAR = 8'h4B;
  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  // Byte 0 of each sequence sits in the lowest bits.
  localparam logic [79:0] PREAMBLE_BYTES = {8'd1, 8'd82, 8'd27, 8'd56, 8'd27,
                                            8'd24, 8'h33, 8'd27, 8'h40, 8'd27};
  localparam logic [39:0] TRAILER_BYTES = {8'd57, 8'd27, 8'd7, 8'd7, 8'd7};

  typedef enum logic [2:0] {
    EMIT_IDLE,
    EMIT_PREAMBLE,
    EMIT_HEADER,
    EMIT_COLUMNS,
    EMIT_NEWLINE,
    EMIT_TRAILER
  } emit_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
  } printer_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] pixel_byte
  logic        s_axis_tuser;   // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] out_byte
  logic [1:0]  m_axis_tuser;   // [1:0] kind

  // Predicted block state and its configuration copy.
  logic [63:0] band_mem [MAX_LINE];
  int unsigned col_idx;
  int unsigned band_row;
  int unsigned page_row;
  int unsigned dark_end;
  int unsigned emit_cnt;
  bit          page_open;
  emit_phase_e phase;
  int unsigned line_cfg;
  int unsigned rows_cfg;
  bit          hires_cfg;

  printer_beat_t pending_printer_bytes [$];
  int unsigned   mismatches;
  bit            blank_band;
  bit            steady;
  bit            hold_request;
  bit            hold_served;

  // Output beats seen at the falling edge, checked at the next rising edge.
  logic        out_seen;
  logic [7:0]  out_data_seen;
  logic [1:0]  out_kind_seen;

  raster_to_column_band_printer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #6_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int unsigned line_limit();
    if (line_cfg == 0) return 1;
    if (line_cfg > MAX_LINE) return MAX_LINE;
    return line_cfg;
  endfunction

  function automatic int unsigned page_limit();
    return (rows_cfg == 0) ? 1 : rows_cfg;
  endfunction

  function automatic void push_beat(input logic [7:0] data, input logic [1:0] kind);
    printer_beat_t b;
    b.data = data;
    b.kind = kind;
    pending_printer_bytes.push_back(b);
  endfunction

  function automatic void clear_band();
    foreach (band_mem[i]) band_mem[i] = '0;
  endfunction

  function automatic void printer_state_reset();
    clear_band();
    col_idx = 0;
    band_row = 0;
    page_row = 0;
    dark_end = 0;
    emit_cnt = 0;
    page_open = 1'b0;
    phase = EMIT_IDLE;
    line_cfg = 120;
    rows_cfg = 792;
    hires_cfg = 1'b1;
  endfunction

  // Folds one raster byte into the band and opens the output when a band is complete.
  function automatic void store_pixels(input logic [7:0] px);
    int unsigned bc;
    int unsigned low;
    int unsigned cand;
    bc = col_idx % MAX_LINE;
    for (int unsigned k = 0; k < 8; k++) begin
      if (px[7 - k]) band_mem[bc][k * 8 + 7 - (band_row & 7)] = 1'b1;
    end
    if (px != 8'h00) begin
      low = 0;
      while (px[low] == 1'b0) low++;
      cand = bc * 8 + 8 - low;
      if (cand > dark_end) dark_end = cand;
    end
    col_idx = bc + 1;
    if (col_idx >= line_limit()) begin
      col_idx = 0;
      page_row = (page_row + 1) & 32'hFFFF;
      band_row++;
      if (band_row >= 8 || page_row >= page_limit()) begin
        band_row = 0;
        emit_cnt = 0;
        if (!page_open) phase = EMIT_PREAMBLE;
        else phase = (dark_end != 0) ? EMIT_HEADER : EMIT_NEWLINE;
      end
    end
  endfunction

  // Works out the printer bytes that one accepted input beat causes.
  function automatic void band_printer_step(input logic cmd, input logic [7:0] px);
    int unsigned c;
    logic [7:0] b;
    if (cmd == CMD_PIXEL) begin
      if (phase != EMIT_IDLE) push_beat(8'h00, KIND_REJECT);
      else store_pixels(px);
      return;
    end
    case (phase)
      EMIT_PREAMBLE: begin
        push_beat(PREAMBLE_BYTES[(emit_cnt % 10) * 8 +: 8], KIND_BYTE);
        emit_cnt++;
        if (emit_cnt >= 10) begin
          page_open = 1'b1;
          emit_cnt = 0;
          phase = (dark_end != 0) ? EMIT_HEADER : EMIT_NEWLINE;
        end
      end
      EMIT_HEADER: begin
        case (emit_cnt)
          0: b = ESC_BYTE;
          1: b = SPACING_CHAR;
          2: b = SPACING_24;
          3: b = ESC_BYTE;
          4: b = hires_cfg ? DENSE_CHAR : SPARSE_CHAR;
          5: b = dark_end[7:0];
          default: b = dark_end[15:8];
        endcase
        push_beat(b, KIND_BYTE);
        emit_cnt++;
        if (emit_cnt >= 7) begin
          emit_cnt = 0;
          phase = EMIT_COLUMNS;
        end
      end
      EMIT_COLUMNS: begin
        c = emit_cnt % (MAX_LINE * 8);
        push_beat(band_mem[c >> 3][(c & 7) * 8 +: 8], KIND_BYTE);
        emit_cnt++;
        if (emit_cnt >= dark_end) begin
          emit_cnt = 0;
          phase = EMIT_NEWLINE;
        end
      end
      EMIT_NEWLINE: begin
        push_beat(NEWLINE_BYTE, KIND_BAND_END);
        clear_band();
        dark_end = 0;
        emit_cnt = 0;
        phase = (page_row >= page_limit()) ? EMIT_TRAILER : EMIT_IDLE;
      end
      EMIT_TRAILER: begin
        if (emit_cnt >= 4) begin
          push_beat(TRAILER_BYTES[39:32], KIND_PAGE_END);
          page_row = 0;
          page_open = 1'b0;
          emit_cnt = 0;
          phase = EMIT_IDLE;
        end else begin
          push_beat(TRAILER_BYTES[emit_cnt * 8 +: 8], KIND_BYTE);
          emit_cnt++;
        end
      end
      default: phase = EMIT_IDLE;
    endcase
  endfunction

  // Raster content: whole blank bands now and then, dark bytes only below the span.
  function automatic logic [7:0] pick_pixel(input int unsigned span);
    int unsigned r;
    if (band_row == 0 && col_idx == 0) blank_band = ($urandom_range(0, 99) < 20);
    r = $urandom_range(0, 99);
    if (blank_band || col_idx >= span || r < 30) return 8'h00;
    if (r < 40) return 8'hFF;
    if (r < 50) return 8'h01 << $urandom_range(0, 7);
    return 8'($urandom_range(1, 255));
  endfunction

  // Offers one beat and predicts its effect once the handshake is certain.
  task automatic send_beat(input logic cmd, input logic [7:0] px);
    bit taken;
    if (!steady && $urandom_range(0, 99) < 12) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= px;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = s_axis_tready;
      if (taken) band_printer_step(cmd, px);
      @(posedge clk_i);
    end
  endtask

  // Stops offering beats and waits until every predicted byte is out.
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (pending_printer_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [7:0] lb, input logic [15:0] pr, input logic hr);
    wait_quiet();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_LINE_BYTES;
    cfg_data_i <= {8'd0, lb};
    @(posedge clk_i);
    cfg_idx_i <= REG_PAGE_ROWS;
    cfg_data_i <= pr;
    @(posedge clk_i);
    cfg_idx_i <= REG_HIGH_RES;
    cfg_data_i <= {15'd0, hr};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    line_cfg = lb;
    rows_cfg = pr;
    hires_cfg = hr;
  endtask

  task automatic drain_band();
    while (phase != EMIT_IDLE) send_beat(CMD_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Mostly well-formed pages: raster rows while idle, ticks while bytes are pending,
  // with stray ticks and pixel beats that the block must reject mixed in.
  task automatic run_phase(input int unsigned n_items, input logic [7:0] lb,
                           input logic [15:0] pr, input logic hr, input int unsigned span);
    int unsigned sent;
    sent = 0;
    set_config(lb, pr, hr);
    while (sent < n_items || phase != EMIT_IDLE) begin
      if (phase == EMIT_IDLE) begin
        if ($urandom_range(0, 99) < 4) begin
          send_beat(CMD_TICK, 8'($urandom_range(0, 255)));
        end else begin
          send_beat(CMD_PIXEL, pick_pixel(span));
          sent++;
        end
      end else begin
        if ($urandom_range(0, 99) < 6) send_beat(CMD_PIXEL, 8'($urandom_range(0, 255)));
        else send_beat(CMD_TICK, 8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  // One-byte lines, one-line pages: an idle tick, a single dot, a rejected pixel.
  task automatic test_single_dot_page();
    set_config(8'd1, 16'd1, 1'b0);
    send_beat(CMD_TICK, 8'hA5);
    send_beat(CMD_PIXEL, 8'h80);
    send_beat(CMD_PIXEL, 8'h5A);
    drain_band();
  endtask

  task automatic test_blank_page();
    send_beat(CMD_PIXEL, 8'h00);
    drain_band();
  endtask

  task automatic test_tall_page();
    run_phase(60, 8'd7, 16'd65535, 1'b1, MAX_LINE);
  endtask

  // Starts with a partial row from the wider line, so the column count passes the limit.
  task automatic test_shrinking_line();
    run_phase(40, 8'd2, 16'd5, 1'b1, MAX_LINE);
  endtask

  task automatic test_zero_registers();
    run_phase(40, 8'd0, 16'd0, 1'b0, MAX_LINE);
  endtask

  task automatic test_unbroken_stream();
    steady = 1'b1;
    run_phase(150, 8'd5, 16'd3, 1'b0, MAX_LINE);
    steady = 1'b0;
  endtask

  task automatic test_full_width_band();
    run_phase(128, 8'd128, 16'd1, 1'b1, MAX_LINE);
  endtask

  task automatic test_clamped_line();
    run_phase(140, 8'd255, 16'd1, 1'b0, 4);
  endtask

  // A dark band is drained while the receiver holds off, so the block must stall its input.
  task automatic test_output_backpressure();
    set_config(8'd4, 16'd4, 1'b1);
    while (phase == EMIT_IDLE) send_beat(CMD_PIXEL, 8'($urandom_range(1, 255)));
    hold_request = 1'b1;
    drain_band();
  endtask

  task automatic test_single_byte_lines();
    run_phase(50, 8'd1, 16'd9, 1'b1, MAX_LINE);
  endtask

  task automatic test_mixed_bands();
    run_phase(50, 8'd3, 16'd12, 1'b0, MAX_LINE);
  endtask

  // Receiver: random stalls, one long hold on request, none while the stream is steady.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  // Sample output beats away from the active edge.
  always @(negedge clk_i) begin
    out_seen <= rst_ni && m_axis_tvalid && m_axis_tready;
    out_data_seen <= m_axis_tdata;
    out_kind_seen <= m_axis_tuser;
  end

  // Compare each output beat with the oldest predicted byte.
  always @(posedge clk_i) begin
    printer_beat_t want;
    if (out_seen === 1'b1) begin
      if (pending_printer_bytes.size() == 0) begin
        $display("%0t: unexpected beat: expected none, got byte %0d kind %0d",
                 $time, out_data_seen, out_kind_seen);
        mismatches++;
      end else begin
        want = pending_printer_bytes.pop_front();
        if (want.data !== out_data_seen || want.kind !== out_kind_seen) begin
          $display("%0t: beat mismatch: expected byte %0d kind %0d, got byte %0d kind %0d",
                   $time, want.data, want.kind, out_data_seen, out_kind_seen);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_LINE_BYTES;
    cfg_data_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= CMD_PIXEL;
    mismatches = 0;
    blank_band = 1'b0;
    steady = 1'b0;
    hold_request = 1'b0;
    hold_served = 1'b0;
    printer_state_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_dot_page();
    test_blank_page();
    test_tall_page();
    test_shrinking_line();
    test_zero_registers();
    test_unbroken_stream();
    test_full_width_band();
    test_clamped_line();
    test_output_backpressure();
    test_single_byte_lines();
    test_mixed_bands();

    wait_quiet();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
